>>> hw/rtl/height_map_gradient_feature_core_assert.svh
// ---------------------------------------------------------------------------
// Height map gradient core assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef HEIGHT_MAP_GRADIENT_FEATURE_CORE_ASSERT_SVH
`define HEIGHT_MAP_GRADIENT_FEATURE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HMGF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HMGF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/hmgf_pkg.sv
// ---------------------------------------------------------------------------
// Height map gradient package
// Shared codes, widths and interface structs of the height map gradient core.
// ---------------------------------------------------------------------------
package hmgf_pkg;

   // transaction function codes
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_ADD   = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_HALF_WIDTH_X = 3'd0;
   localparam logic [2:0] REG_HALF_WIDTH_Y = 3'd1;
   localparam logic [2:0] REG_BOX_DEPTH    = 3'd2;
   localparam logic [2:0] REG_BOX_TOP      = 3'd3;
   localparam logic [2:0] REG_CPM_X        = 3'd4;
   localparam logic [2:0] REG_CPM_Y        = 3'd5;
   localparam logic [2:0] REG_GRAD_LIMIT   = 3'd6;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // register reset values
   localparam logic [14:0]        RST_HALF_WIDTH = 15'd410;
   localparam logic [14:0]        RST_BOX_DEPTH  = 15'd410;
   localparam logic signed [15:0] RST_BOX_TOP    = 16'sd41;
   localparam logic [19:0]        RST_CPM        = 20'd40960;
   localparam logic [15:0]        RST_GRAD_LIMIT = 16'd2458;

   // -1 m in 1/4096 m
   localparam logic signed [15:0] EMPTY_HEIGHT = -16'sd4096;

   // shared multiplier: 16 x 20 unsigned
   localparam int MUL_A_W   = 16;
   localparam int MUL_B_W   = 20;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int BIN_SHIFT = 20;

   // square root: radicand is the sum of two 32-bit squares
   localparam int RAD_W  = 33;
   localparam int ROOT_W = 16;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

>>> hw/rtl/hmgf_mul_unit.sv
// ---------------------------------------------------------------------------
// Shared multiplier
// Registered unsigned multiplier reused for binning, squaring and the limit.
// ---------------------------------------------------------------------------
module hmgf_mul_unit
   import hmgf_pkg::*;
(
   input  logic               clock,
   input  mul_req_type        mul_req,
   output logic [MUL_P_W-1:0] mul_prod
);

   logic [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);
   end

   assign mul_prod = prod_ff;

endmodule

>>> hw/rtl/hmgf_sqrt_unit.sv
// ---------------------------------------------------------------------------
// Iterative square root
// Floor square root, one result bit per cycle, restoring digit recurrence.
// ---------------------------------------------------------------------------
module hmgf_sqrt_unit
   import hmgf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type sqrt_req,
   output sqrt_rsp_type sqrt_rsp
);

   localparam int RW      = RAD_W + 1;
   localparam int TOP_POS = ((RAD_W - 1) / 2) * 2;

   logic [RW-1:0] rem_ff;
   logic [RW-1:0] rem_in;
   logic [RW-1:0] res_ff;
   logic [RW-1:0] res_in;
   logic [RW-1:0] one_ff;
   logic [RW-1:0] one_in;
   logic          busy_ff;
   logic          busy_in;
   logic          done_ff;
   logic          done_in;
   logic [RW-1:0] trial;

   assign trial = res_ff + one_ff;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      one_in  = one_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + one_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         one_in = one_ff >> 2;
         // last digit position reached
         if (one_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (sqrt_req.start) begin
         rem_in  = RW'(sqrt_req.radicand);
         res_in  = '0;
         one_in  = RW'(1) << TOP_POS;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      one_ff <= one_in;
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = res_ff[ROOT_W-1:0];

endmodule

>>> hw/rtl/height_map_gradient_feature_core.sv
// Steps: clear writes one cell a cycle; an added point is binned by two shared
// multiplies, then its cell is read and updated; a dropped point or unused code stays
// idle. Interior query: 4 cell reads, 3 shared multiplies, 17-step sqrt if in limit.
// Throughput: one transaction at a time, set by the sequencer and sqrt unit.
// Reset: synchronous; state and configuration registers take reset values and
// a GRID_COLS*GRID_ROWS cell clearing pass runs, req_ready low until it ends.
// ---------------------------------------------------------------------------
// Height map gradient core
// Max-height binning of 3D points into a grid and gradient magnitude queries.
// ---------------------------------------------------------------------------
`include "height_map_gradient_feature_core_assert.svh"

module height_map_gradient_feature_core
   import hmgf_pkg::*;
#(
   parameter int GRID_COLS = 32,
   parameter int GRID_ROWS = 32
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic signed [15:0]  req_point_x,
   input  logic signed [15:0]  req_point_y,
   input  logic signed [15:0]  req_point_z,
   input  logic [4:0]          req_query_col,
   input  logic [4:0]          req_query_row,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_gradient,
   output logic                rsp_status,
   // configuration port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int MEM_DEPTH = GRID_COLS * GRID_ROWS;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int COL_W     = $clog2(GRID_COLS);
   localparam int ROW_W     = $clog2(GRID_ROWS);

   localparam logic [AW-1:0] CLR_LAST    = AW'(MEM_DEPTH - 1);
   localparam logic [AW-1:0] COLS_A      = AW'(GRID_COLS);
   localparam logic [8:0]    COL_MAX_IN  = 9'(GRID_COLS - 2);
   localparam logic [8:0]    ROW_MAX_IN  = 9'(GRID_ROWS - 2);
   localparam logic [15:0]   COLS_16     = 16'(GRID_COLS);
   localparam logic [15:0]   ROWS_16     = 16'(GRID_ROWS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CLR  = 4'd1;
   localparam logic [3:0] S_MULX = 4'd2;
   localparam logic [3:0] S_MULY = 4'd3;
   localparam logic [3:0] S_ROWL = 4'd4;
   localparam logic [3:0] S_PRD  = 4'd5;
   localparam logic [3:0] S_PUPD = 4'd6;
   localparam logic [3:0] S_QRD  = 4'd7;
   localparam logic [3:0] S_SQX  = 4'd8;
   localparam logic [3:0] S_SQY  = 4'd9;
   localparam logic [3:0] S_LIM  = 4'd10;
   localparam logic [3:0] S_CMP  = 4'd11;
   localparam logic [3:0] S_SQRT = 4'd12;
   localparam logic [3:0] S_DONE = 4'd13;

   // configuration registers
   logic [14:0]        hwx_ff;
   logic [14:0]        hwy_ff;
   logic [14:0]        depth_ff;
   logic signed [15:0] top_ff;
   logic [19:0]        cpmx_ff;
   logic [19:0]        cpmy_ff;
   logic [15:0]        limit_ff;

   logic               csr_wr;
   logic [2:0]         csr_idx;

   // sequencer
   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [2:0]         step_ff, step_in;
   logic [15:0]        sx_ff, sx_in;
   logic [15:0]        sy_ff, sy_in;
   logic signed [15:0] z_ff, z_in;
   logic [4:0]         qcol_ff, qcol_in;
   logic [4:0]         qrow_ff, qrow_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic signed [15:0] left_ff, left_in;
   logic signed [15:0] up_ff, up_in;
   logic [15:0]        adx_ff, adx_in;
   logic [15:0]        ady_ff, ady_in;
   logic [RAD_W-1:0]   acc_ff, acc_in;
   logic [15:0]        grad_ff, grad_in;
   logic               stat_ff, stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_gradient_ff, rsp_gradient_in;
   logic               rsp_status_ff, rsp_status_in;

   // memory
   logic signed [15:0] cells_mem [MEM_DEPTH];
   logic signed [15:0] rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_addr;
   logic signed [15:0] mem_wdata;

   // shared units
   mul_req_type        mul_req;
   logic [MUL_P_W-1:0] mul_prod;
   sqrt_req_type       sqrt_req;
   sqrt_rsp_type       sqrt_rsp;

   // request decode
   logic               req_fire;
   logic signed [16:0] xs17, ys17, zs17;
   logic signed [16:0] sum_x, sum_y, sum_z;
   logic               in_box;
   logic               interior;

   // derived values
   logic [15:0]        bin_val;
   logic [COL_W-1:0]   sat_col;
   logic [ROW_W-1:0]   sat_row;
   logic [AW-1:0]      point_addr;
   logic [AW-1:0]      base_addr;
   logic [AW-1:0]      nb_addr;
   logic signed [16:0] diff;
   logic [16:0]        diff_mag;
   logic signed [15:0] diff_ref;
   logic [31:0]        prod_lo;

   // -----------------------------------------------------------------------
   // configuration port
   // -----------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hwx_ff   <= RST_HALF_WIDTH;
         hwy_ff   <= RST_HALF_WIDTH;
         depth_ff <= RST_BOX_DEPTH;
         top_ff   <= RST_BOX_TOP;
         cpmx_ff  <= RST_CPM;
         cpmy_ff  <= RST_CPM;
         limit_ff <= RST_GRAD_LIMIT;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_HALF_WIDTH_X: hwx_ff   <= csr_pwdata[14:0];
            REG_HALF_WIDTH_Y: hwy_ff   <= csr_pwdata[14:0];
            REG_BOX_DEPTH:    depth_ff <= csr_pwdata[14:0];
            REG_BOX_TOP:      top_ff   <= csr_pwdata[15:0];
            REG_CPM_X:        cpmx_ff  <= csr_pwdata[19:0];
            REG_CPM_Y:        cpmy_ff  <= csr_pwdata[19:0];
            REG_GRAD_LIMIT:   limit_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HALF_WIDTH_X: csr_prdata = {17'd0, hwx_ff};
         REG_HALF_WIDTH_Y: csr_prdata = {17'd0, hwy_ff};
         REG_BOX_DEPTH:    csr_prdata = {17'd0, depth_ff};
         REG_BOX_TOP:      csr_prdata = {{16{top_ff[15]}}, top_ff};
         REG_CPM_X:        csr_prdata = {12'd0, cpmx_ff};
         REG_CPM_Y:        csr_prdata = {12'd0, cpmy_ff};
         REG_GRAD_LIMIT:   csr_prdata = {16'd0, limit_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // -----------------------------------------------------------------------
   // request decode: box test and grid offset in one add per axis
   // -----------------------------------------------------------------------
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign xs17  = {req_point_x[15], req_point_x};
   assign ys17  = {req_point_y[15], req_point_y};
   assign zs17  = {req_point_z[15], req_point_z};
   assign sum_x = xs17 + $signed({2'b00, hwx_ff});
   assign sum_y = ys17 + $signed({2'b00, hwy_ff});
   assign sum_z = zs17 + $signed({2'b00, depth_ff});

   // a nonnegative sum means the coordinate is at or above the lower bound
   assign in_box = !sum_x[16] && (xs17 <= $signed({2'b00, hwx_ff})) &&
                   !sum_y[16] && (ys17 <= $signed({2'b00, hwy_ff})) &&
                   !sum_z[16] && (req_point_z <= top_ff);

   assign interior = ({4'd0, req_query_col} >= 9'd1) &&
                     ({4'd0, req_query_col} <= COL_MAX_IN) &&
                     ({4'd0, req_query_row} >= 9'd1) &&
                     ({4'd0, req_query_row} <= ROW_MAX_IN);

   // -----------------------------------------------------------------------
   // addressing and datapath helpers
   // -----------------------------------------------------------------------
   assign bin_val = mul_prod[MUL_P_W-1:BIN_SHIFT];
   assign sat_col = (bin_val >= COLS_16) ? COL_W'(GRID_COLS - 1) : bin_val[COL_W-1:0];
   assign sat_row = (bin_val >= ROWS_16) ? ROW_W'(GRID_ROWS - 1) : bin_val[ROW_W-1:0];

   assign point_addr = AW'(row_ff) * COLS_A + AW'(col_ff);
   assign base_addr  = AW'(qrow_ff) * COLS_A + AW'(qcol_ff);

   always_comb begin
      case (step_ff[1:0])
         2'd0:    nb_addr = base_addr - AW'(1);
         2'd1:    nb_addr = base_addr + AW'(1);
         2'd2:    nb_addr = base_addr - COLS_A;
         default: nb_addr = base_addr + COLS_A;
      endcase
   end

   // central difference of the stored neighbor and the cell just read
   assign diff_ref = (step_ff == 3'd2) ? left_ff : up_ff;
   assign diff     = {diff_ref[15], diff_ref} - {rd_data_ff[15], rd_data_ff};
   assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
   assign prod_lo  = mul_prod[31:0];

   // -----------------------------------------------------------------------
   // sequencer
   // -----------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      step_in         = step_ff;
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      z_in            = z_ff;
      qcol_in         = qcol_ff;
      qrow_in         = qrow_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      left_in         = left_ff;
      up_in           = up_ff;
      adx_in          = adx_ff;
      ady_in          = ady_ff;
      acc_in          = acc_ff;
      grad_in         = grad_ff;
      stat_in         = stat_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_gradient_in = rsp_gradient_ff;
      rsp_status_in   = rsp_status_ff;
      mem_we          = 1'b0;
      mem_addr        = point_addr;
      mem_wdata       = z_ff;
      mul_req.a       = '0;
      mul_req.b       = '0;
      sqrt_req.start    = 1'b0;
      sqrt_req.radicand = acc_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_func)
                  FUNC_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLR;
                  end
                  FUNC_ADD: begin
                     sx_in = sum_x[15:0];
                     sy_in = sum_y[15:0];
                     z_in  = req_point_z;
                     if (in_box) begin
                        state_in = S_MULX;
                     end
                  end
                  FUNC_QUERY: begin
                     qcol_in = req_query_col;
                     qrow_in = req_query_row;
                     step_in = '0;
                     if (interior) begin
                        state_in = S_QRD;
                     end else begin
                        grad_in  = '0;
                        stat_in  = 1'b1;
                        state_in = S_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CLR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = EMPTY_HEIGHT;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_MULX: begin
            mul_req.a = sx_ff;
            mul_req.b = cpmx_ff;
            state_in  = S_MULY;
         end
         S_MULY: begin
            col_in    = sat_col;
            mul_req.a = sy_ff;
            mul_req.b = cpmy_ff;
            state_in  = S_ROWL;
         end
         S_ROWL: begin
            row_in   = sat_row;
            state_in = S_PRD;
         end
         S_PRD: begin
            state_in = S_PUPD;
         end
         S_PUPD: begin
            // keep the highest z of the cell
            if (z_ff > rd_data_ff) begin
               mem_we = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_QRD: begin
            mem_addr = nb_addr;
            step_in  = step_ff + 3'd1;
            case (step_ff)
               3'd1: left_in = rd_data_ff;
               3'd2: adx_in  = diff_mag[15:0];
               3'd3: up_in   = rd_data_ff;
               3'd4: begin
                  ady_in   = diff_mag[15:0];
                  state_in = S_SQX;
               end
               default: ;
            endcase
         end
         S_SQX: begin
            mul_req.a = adx_ff;
            mul_req.b = MUL_B_W'(adx_ff);
            state_in  = S_SQY;
         end
         S_SQY: begin
            acc_in    = RAD_W'(prod_lo);
            mul_req.a = ady_ff;
            mul_req.b = MUL_B_W'(ady_ff);
            state_in  = S_LIM;
         end
         S_LIM: begin
            acc_in    = acc_ff + RAD_W'(prod_lo);
            mul_req.a = limit_ff;
            mul_req.b = MUL_B_W'(limit_ff);
            state_in  = S_CMP;
         end
         S_CMP: begin
            stat_in = 1'b0;
            // magnitude above the limit reads as zero
            if (acc_ff > RAD_W'(prod_lo)) begin
               grad_in  = '0;
               state_in = S_DONE;
            end else begin
               sqrt_req.start = 1'b1;
               state_in       = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_rsp.done) begin
               grad_in  = sqrt_rsp.root;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_gradient_in = grad_ff;
               rsp_status_in   = stat_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff           <= sx_in;
      sy_ff           <= sy_in;
      z_ff            <= z_in;
      qcol_ff         <= qcol_in;
      qrow_ff         <= qrow_in;
      col_ff          <= col_in;
      row_ff          <= row_in;
      left_ff         <= left_in;
      up_ff           <= up_in;
      adx_ff          <= adx_in;
      ady_ff          <= ady_in;
      acc_ff          <= acc_in;
      grad_ff         <= grad_in;
      stat_ff         <= stat_in;
      rsp_gradient_ff <= rsp_gradient_in;
      rsp_status_ff   <= rsp_status_in;
   end

   // -----------------------------------------------------------------------
   // height cell memory
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= cells_mem[mem_addr];
   end

   // -----------------------------------------------------------------------
   // shared units
   // -----------------------------------------------------------------------
   hmgf_mul_unit u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   hmgf_sqrt_unit u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gradient = rsp_gradient_ff;
   assign rsp_status   = rsp_status_ff;

   // -----------------------------------------------------------------------
   // assertions
   // -----------------------------------------------------------------------
   `HMGF_ASSERT_NOW(a_border_zero, clock, reset, rsp_valid_ff && rsp_status_ff,
      rsp_gradient_ff == 16'd0, "border query response carries nonzero gradient")
   `HMGF_ASSERT_NOW(a_sqrt_owner, clock, reset, sqrt_rsp.done, state_ff == S_SQRT,
      "square root finished outside its wait state")
   `HMGF_ASSERT_NEXT(a_clear_end, clock, reset, state_ff == S_CLR && clr_ff == CLR_LAST,
      state_ff == S_IDLE, "clearing pass did not end after the last cell")
   `HMGF_ASSERT_NEXT(a_query_start, clock, reset, req_fire && req_func == FUNC_QUERY,
      state_ff == S_QRD || state_ff == S_DONE, "query transaction did not start")

endmodule
